@@ rtl/core/spl_pkg.sv @@
// Shared types, constants and saturation helpers for the cubic spline evaluator.
// Depends on nothing; every other file in rtl/core imports it.
package spl_pkg;

	localparam int MAX_KNOTS = 64;
	localparam int KAW       = $clog2(MAX_KNOTS);
	localparam int KC_W      = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 48;

	localparam logic [1:0] CMD_KNOT = 2'd0;
	localparam logic [1:0] CMD_COEF = 2'd1;
	localparam logic [1:0] CMD_EVAL = 2'd2;

	localparam logic [2:0] REG_KNOT_COUNT = 3'd0;
	localparam logic [2:0] REG_X_BIAS     = 3'd1;
	localparam logic [2:0] REG_INV_SCALE  = 3'd2;
	localparam logic [2:0] REG_Y_BIAS     = 3'd3;
	localparam logic [2:0] REG_SCALE_Y    = 3'd4;

	localparam logic [1:0] SEL_CUBIC  = 2'd0;
	localparam logic [1:0] SEL_SQUARE = 2'd1;
	localparam logic [1:0] SEL_LINEAR = 2'd2;
	localparam logic [1:0] SEL_CONST  = 2'd3;

	localparam logic [1:0] FLAG_IN    = 2'd0;
	localparam logic [1:0] FLAG_BELOW = 2'd1;
	localparam logic [1:0] FLAG_ABOVE = 2'd2;

	localparam logic [1:0] SH_18 = 2'd0;
	localparam logic [1:0] SH_30 = 2'd1;
	localparam logic [1:0] SH_32 = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         index;
		logic [1:0]         sel;
		logic signed [47:0] value;
		logic signed [31:0] x_in;
	} item_t;

	typedef struct packed {
		logic [KC_W-1:0]    knot_count;
		logic signed [31:0] x_bias;
		logic [47:0]        inv_scale_x;
		logic signed [31:0] y_bias;
		logic [31:0]        scale_y;
	} cfg_t;

	typedef struct packed {
		logic [47:0] a_mag;
		logic [32:0] b_mag;
		logic        neg;
		logic [1:0]  sh;
	} mul_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		if (v < -64'sh8000_0000_0000) return -48'sh8000_0000_0000;
		return v[47:0];
	endfunction

endpackage

@@ rtl/core/spl_front.sv @@
// Front end: takes command beats, drops ones that do nothing, saturates knots.
// Depends on spl_pkg.
module spl_front import spl_pkg::*; (
	input  logic               start,
	input  logic               q_full,
	input  logic [1:0]         command,
	input  logic [5:0]         index,
	input  logic [1:0]         coef_sel,
	input  logic signed [47:0] value,
	input  logic signed [31:0] x_in,
	output logic               push,
	output item_t              item
);
	logic take;
	logic keep;

	assign take = start & ~q_full;

	always_comb begin
		unique case (command)
			CMD_KNOT: keep = (int'(index) < MAX_KNOTS);
			CMD_COEF: keep = (int'(index) < MAX_KNOTS - 1);
			CMD_EVAL: keep = 1'b1;
			default:  keep = 1'b0;
		endcase
	end

	assign push = take & keep;

	always_comb begin
		item.kind  = command;
		item.index = index;
		item.sel   = coef_sel;
		item.x_in  = x_in;
		// knots are stored as Q2.30, so clip the written value to 32 bits
		if (command == CMD_KNOT)
			item.value = 48'(sat32(64'(value)));
		else
			item.value = value;
	end
endmodule

@@ rtl/core/spl_queue.sv @@
// Two-entry show-ahead queue between the front end and the evaluator.
// Depends on spl_pkg.
module spl_queue import spl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);
	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ rtl/core/spl_mul.sv @@
// Shared 48x33 multiplier, two 24-bit partial products, floored shift.
// Depends on spl_pkg.
module spl_mul import spl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  mul_req_t           req,
	output logic               done,
	output logic signed [63:0] res
);
	mul_req_t            req_q;
	logic [1:0]          ph_q;
	logic [56:0]         hi_s1;
	logic [56:0]         lo_s2;
	logic [80:0]         mag;
	logic signed [81:0]  sgn;
	logic signed [81:0]  shd;

	always_comb begin
		mag = {hi_s1, 24'b0} + 81'(lo_s2);
		sgn = req_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		case (req_q.sh)
			SH_18:   shd = sgn >>> 18;
			SH_30:   shd = sgn >>> 30;
			default: shd = sgn >>> 32;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go) req_q <= req;
		if (ph_q == 2'd1) hi_s1 <= {33'd0, req_q.a_mag[47:24]} * {24'd0, req_q.b_mag};
		if (ph_q == 2'd2) lo_s2 <= {33'd0, req_q.a_mag[23:0]} * {24'd0, req_q.b_mag};
		if (ph_q == 2'd3) res <= shd[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= (ph_q == 2'd3);
			if (go) ph_q <= 2'd1;
			else if (ph_q != 2'd0) ph_q <= ph_q + 2'd1;
		end
	end
endmodule

@@ rtl/core/spl_back.sv @@
// Evaluator: owns knot and coefficient memories, segment search and Horner steps.
// Depends on spl_pkg and spl_mul.
module spl_back import spl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_empty,
	input  item_t              head,
	output logic               pop,
	output logic               result_valid,
	output logic signed [31:0] y_out,
	output logic [5:0]         segment,
	output logic [1:0]         range_flag
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_NORM  = 4'd1;
	localparam logic [3:0] S_NWAIT = 4'd2;
	localparam logic [3:0] S_RK0   = 4'd3;
	localparam logic [3:0] S_RKL   = 4'd4;
	localparam logic [3:0] S_CLS   = 4'd5;
	localparam logic [3:0] S_SRD   = 4'd6;
	localparam logic [3:0] S_SCMP  = 4'd7;
	localparam logic [3:0] S_RSEG  = 4'd8;
	localparam logic [3:0] S_DIST  = 4'd9;
	localparam logic [3:0] S_HMUL  = 4'd10;
	localparam logic [3:0] S_HWAIT = 4'd11;
	localparam logic [3:0] S_YMUL  = 4'd12;
	localparam logic [3:0] S_YWAIT = 4'd13;

	logic [31:0]        knot_mem [MAX_KNOTS];
	logic [47:0]        c3_mem [MAX_KNOTS-1];
	logic [47:0]        c2_mem [MAX_KNOTS-1];
	logic [47:0]        c1_mem [MAX_KNOTS-1];
	logic [47:0]        c0_mem [MAX_KNOTS-1];

	logic [3:0]         st_q;
	logic [KAW-1:0]     rd_addr;
	logic signed [31:0] knot_rd_q;
	logic signed [47:0] c3_q, c2_q, c1_q, c0_q;
	item_t              it_q;
	logic signed [63:0] xn_q;
	logic signed [63:0] k0_q;
	logic signed [63:0] prev_q;
	logic signed [63:0] cur;
	logic [KAW-1:0]     i_q;
	logic [KAW-1:0]     seg_q;
	logic [1:0]         flag_q;
	logic signed [31:0] dist_q;
	logic signed [47:0] acc_q;
	logic [1:0]         step_q;
	logic [KC_W-1:0]    kc;
	logic [KAW-1:0]     last_k;
	logic [KAW-1:0]     last_seg;
	logic signed [32:0] diff;
	logic               mul_go;
	mul_req_t           mreq;
	logic               mul_done;
	logic signed [63:0] mul_res;
	logic signed [47:0] nxt_coef;

	// clamp the knot count into the legal span
	always_comb begin
		if (cfg.knot_count < KC_W'(2)) kc = KC_W'(2);
		else if (int'(cfg.knot_count) > MAX_KNOTS) kc = KC_W'(MAX_KNOTS);
		else kc = cfg.knot_count;
		last_k   = KAW'(kc - KC_W'(1));
		last_seg = KAW'(kc - KC_W'(2));
	end

	assign diff = 33'(it_q.x_in) - 33'(cfg.x_bias);
	assign cur  = 64'(knot_rd_q);
	assign pop  = (st_q == S_IDLE) & ~q_empty;

	always_comb begin
		unique case (st_q)
			S_RK0:   rd_addr = '0;
			S_RKL:   rd_addr = last_k;
			S_SRD:   rd_addr = i_q + KAW'(1);
			default: rd_addr = seg_q;
		endcase
	end

	always_comb begin
		mul_go = (st_q == S_NORM) | (st_q == S_HMUL) | (st_q == S_YMUL);
		mreq   = '0;
		unique case (st_q)
			S_NORM: begin
				mreq.a_mag = cfg.inv_scale_x;
				mreq.b_mag = diff[32] ? 33'(-diff) : 33'(diff);
				mreq.neg   = diff[32];
				mreq.sh    = SH_18;
			end
			S_HMUL: begin
				mreq.a_mag = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
				mreq.b_mag = dist_q[31] ? 33'(-33'(dist_q)) : 33'(dist_q);
				mreq.neg   = acc_q[47] ^ dist_q[31];
				mreq.sh    = SH_30;
			end
			default: begin
				mreq.a_mag = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
				mreq.b_mag = 33'(cfg.scale_y);
				mreq.neg   = acc_q[47];
				mreq.sh    = SH_32;
			end
		endcase
	end

	always_comb begin
		case (step_q)
			2'd0:    nxt_coef = c2_q;
			2'd1:    nxt_coef = c1_q;
			default: nxt_coef = c0_q;
		endcase
	end

	spl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.req    (mreq),
		.done   (mul_done),
		.res    (mul_res)
	);

	// table writes happen as the write beat leaves the queue
	always_ff @(posedge clk) begin
		if (pop && head.kind == CMD_KNOT)
			knot_mem[KAW'(head.index)] <= head.value[31:0];
		if (pop && head.kind == CMD_COEF) begin
			case (head.sel)
				SEL_CUBIC:  c3_mem[head.index] <= head.value;
				SEL_SQUARE: c2_mem[head.index] <= head.value;
				SEL_LINEAR: c1_mem[head.index] <= head.value;
				default:    c0_mem[head.index] <= head.value;
			endcase
		end
		knot_rd_q <= knot_mem[rd_addr];
		c3_q      <= c3_mem[seg_q];
		c2_q      <= c2_mem[seg_q];
		c1_q      <= c1_mem[seg_q];
		c0_q      <= c0_mem[seg_q];
	end

	always_ff @(posedge clk) begin
		if (pop) it_q <= head;
		if (st_q == S_NWAIT && mul_done) xn_q <= mul_res;
		if (st_q == S_RKL) k0_q <= cur;
		if (st_q == S_DIST) dist_q <= sat32(xn_q - cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			result_valid <= 1'b0;
			y_out        <= '0;
			segment      <= '0;
			range_flag   <= FLAG_IN;
			i_q          <= '0;
			seg_q        <= '0;
			flag_q       <= FLAG_IN;
			acc_q        <= '0;
			step_q       <= '0;
			prev_q       <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (pop && head.kind == CMD_EVAL) st_q <= S_NORM;
				S_NORM: st_q <= S_NWAIT;
				S_NWAIT: if (mul_done) st_q <= S_RK0;
				S_RK0: st_q <= S_RKL;
				S_RKL: st_q <= S_CLS;
				S_CLS: begin
					if (xn_q >= k0_q && xn_q <= cur) begin
						i_q    <= '0;
						prev_q <= k0_q;
						st_q   <= S_SRD;
					end else if (xn_q < k0_q) begin
						seg_q  <= '0;
						flag_q <= FLAG_BELOW;
						st_q   <= S_RSEG;
					end else begin
						seg_q  <= last_seg;
						flag_q <= FLAG_ABOVE;
						st_q   <= S_RSEG;
					end
				end
				S_SRD: st_q <= S_SCMP;
				S_SCMP: begin
					if (xn_q >= prev_q && xn_q <= cur) begin
						seg_q  <= i_q;
						flag_q <= FLAG_IN;
						st_q   <= S_RSEG;
					end else if (i_q == last_seg) begin
						seg_q  <= '0;
						flag_q <= FLAG_IN;
						st_q   <= S_RSEG;
					end else begin
						prev_q <= cur;
						i_q    <= i_q + KAW'(1);
						st_q   <= S_SRD;
					end
				end
				S_RSEG: st_q <= S_DIST;
				S_DIST: begin
					acc_q  <= c3_q;
					step_q <= '0;
					st_q   <= S_HMUL;
				end
				S_HMUL: st_q <= S_HWAIT;
				S_HWAIT: if (mul_done) begin
					acc_q <= sat48(mul_res + 64'(nxt_coef));
					if (step_q == 2'd2) st_q <= S_YMUL;
					else begin
						step_q <= step_q + 2'd1;
						st_q   <= S_HMUL;
					end
				end
				S_YMUL: st_q <= S_YWAIT;
				S_YWAIT: if (mul_done) begin
					y_out        <= sat32(mul_res + 64'(cfg.y_bias));
					segment      <= 6'(seg_q);
					range_flag   <= flag_q;
					result_valid <= 1'b1;
					st_q         <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/piecewise_cubic_spline_eval_unit.sv @@
// Top level of the piecewise cubic spline evaluator: config registers and wiring.
// Depends on spl_pkg, spl_front, spl_queue, spl_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  command   | start / busy         | command, index, coef_sel, value, x_in
//  result    | result_valid strobe  | y_out, segment, range_flag
//  config    | cfg_we               | cfg_idx, cfg_data
//
// A write beat updates its table as it leaves the queue. An evaluate beat holds
// the evaluator from its pop to the result strobe, and longer for every knot
// pair visited in the segment search (at most 63 pairs): it runs five multiplies
// on the shared multiplier, plus the knot reads, classification and the
// coefficient fetch. busy rises only while the two-entry queue is full; the
// front keeps taking beats while the evaluator works. Reset clears control state
// and loads the register defaults; tables hold garbage until written. Results
// are strobed for one cycle and the receiver cannot stall them.
module piecewise_cubic_spline_eval_unit import spl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           command,
	input  logic [5:0]           index,
	input  logic [1:0]           coef_sel,
	input  logic signed [47:0]   value,
	input  logic signed [31:0]   x_in,
	output logic                 result_valid,
	output logic signed [31:0]   y_out,
	output logic [5:0]           segment,
	output logic [1:0]           range_flag,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);
	cfg_t  cfg_q;
	logic  push;
	item_t item;
	item_t head;
	logic  pop;
	logic  q_full;
	logic  q_empty;

	// hold the configuration; writes must come only while the block is idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knot_count  <= KC_W'(2);
			cfg_q.x_bias      <= '0;
			cfg_q.inv_scale_x <= 48'h1_0000_0000;
			cfg_q.y_bias      <= '0;
			cfg_q.scale_y     <= 32'h0001_0000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KNOT_COUNT: cfg_q.knot_count  <= cfg_data[KC_W-1:0];
				REG_X_BIAS:     cfg_q.x_bias      <= cfg_data[31:0];
				REG_INV_SCALE:  cfg_q.inv_scale_x <= cfg_data[47:0];
				REG_Y_BIAS:     cfg_q.y_bias      <= cfg_data[31:0];
				REG_SCALE_Y:    cfg_q.scale_y     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign busy = q_full;

	spl_front u_front (
		.start    (start),
		.q_full   (q_full),
		.command  (command),
		.index    (index),
		.coef_sel (coef_sel),
		.value    (value),
		.x_in     (x_in),
		.push     (push),
		.item     (item)
	);

	spl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (item),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	spl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.y_out        (y_out),
		.segment      (segment),
		.range_flag   (range_flag)
	);
endmodule
